// ===== rtl/pwqc_pkg.sv =====
// Shared types and constants of the pulse width qualified counter.
// Payload structs, per-pin state entry, configuration bundle and codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwqc_pkg;

    localparam int PIN_W      = 6;
    localparam int TICK_W     = 32;
    localparam int COUNT_W    = 64;
    localparam int PERIOD_W   = 23;
    localparam int REJECT_W   = 16;
    localparam int MASK_W     = 64;
    localparam int EXP_W      = 7;
    localparam int BOUND_W    = 20;
    localparam int TOL_W      = 17;
    localparam int WIN_W      = 18;   // expected window bounds, up to 127000 + 131071
    localparam int CFG_ADDR_W = 3;

    // Reset values of the configuration registers
    localparam logic [BOUND_W-1:0] DEF_MIN_WIDTH_US = 20'd30000;
    localparam logic [BOUND_W-1:0] DEF_MAX_WIDTH_US = 20'd120000;
    localparam logic [TOL_W-1:0]   DEF_TOLERANCE_US = 17'd2000;
    localparam logic [9:0]         US_PER_MS        = 10'd1000;
    localparam logic [REJECT_W-1:0] REJECT_RESET    = 16'd2;
    localparam logic [REJECT_W-1:0] REJECT_MAX      = 16'hFFFF;

    // x / 1000 == (x * DIV1000_RECIP) >> DIV1000_SHIFT, exact for any 32-bit x
    localparam int                DIV1000_SHIFT = 38;
    localparam logic [28:0]       DIV1000_RECIP = 29'd274877907;
    localparam int                DIV_PROD_W    = 61;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLE_MASK   = 3'd0,
        REG_INVERTED_MASK = 3'd1,
        REG_EXPECTED_MS   = 3'd2,
        REG_MIN_WIDTH     = 3'd3,
        REG_MAX_WIDTH     = 3'd4,
        REG_TOLERANCE     = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_RISE         = 3'd0,
        ST_COUNTED      = 3'd1,
        ST_NO_RISE      = 3'd2,
        ST_DEFAULT_WIN  = 3'd3,
        ST_EXPECTED_WIN = 3'd4,
        ST_DISABLED     = 3'd5
    } status_t;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_index;
        logic              edge_level;
        logic [TICK_W-1:0] tick_us;
    } pwqc_in_t;

    typedef struct packed {
        logic [PIN_W-1:0]    event_pin;
        status_t             status;
        logic [COUNT_W-1:0]  pulse_total;
        logic [PERIOD_W-1:0] period_ms;
        logic [TICK_W-1:0]   width_us;
        logic [REJECT_W-1:0] reject_count;
        logic                period_valid;
    } pwqc_out_t;

    // One per-pin memory entry
    typedef struct packed {
        logic [COUNT_W-1:0]  pulse_count;
        logic [TICK_W-1:0]   last_accept;
        logic [TICK_W-1:0]   last_rise;
        logic [PERIOD_W-1:0] period_ms;
        logic [REJECT_W-1:0] reject;
        logic                seen_rise;
    } pwqc_entry_t;

    localparam pwqc_entry_t ENTRY_RESET = '{
        pulse_count: '0,
        last_accept: '0,
        last_rise:   '0,
        period_ms:   '0,
        reject:      REJECT_RESET,
        seen_rise:   1'b0
    };

    typedef struct packed {
        logic [MASK_W-1:0]  enable_mask;
        logic [MASK_W-1:0]  inverted_mask;
        logic [EXP_W-1:0]   expected_width_ms;
        logic [BOUND_W-1:0] min_width_us;
        logic [BOUND_W-1:0] max_width_us;
        logic [WIN_W-1:0]   exp_lo;
        logic [WIN_W-1:0]   exp_hi;
    } pwqc_cfg_t;

    // Result of evaluating one edge, carried down the pipeline
    typedef struct packed {
        logic [PIN_W-1:0]  pin;
        status_t           status;
        logic [TICK_W-1:0] width;
        logic [TICK_W-1:0] delta;
        logic              counted;
        logic              wr_en;
        pwqc_entry_t       entry;
    } pwqc_rec_t;

endpackage

`default_nettype wire

// ===== rtl/pulse_width_qualified_counter.sv =====
// Top level of the pulse width qualified counter: handshakes, the
// read-evaluate-divide-write pipeline and the output register.
// Depends on pwqc_pkg, pwqc_cfg, pwqc_state_mem and pwqc_eval.
//
//  channel   dir  handshake           payload
//  s_        in   s_valid / s_ready   s_data  (pwqc_in_t: pin, level, tick)
//  m_        out  m_valid / m_ready   m_data  (pwqc_out_t: one result per edge)
//  cfg_      in   cfg_we              cfg_addr, cfg_wdata (no read-back)
//
// m_valid rises once the s_ transaction has passed the RAM read, evaluate and divide-by-1000
// multiply stages; write-back and the output register load on the same edge.
// Edges on different pins are taken one per cycle unless a stall on m_ready holds the
// pipeline. An edge on a pin still in the pipeline waits for that pin's write-back.
// Reset is synchronous on aresetn; RAM valid bits are cleared at once and s_ready is
// low during reset. A stall on m_ready backs up stage by stage.
`timescale 1ns / 1ps
`default_nettype none

module pulse_width_qualified_counter #(
    parameter int NUM_PINS = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  pwqc_pkg::pwqc_in_t                   s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output pwqc_pkg::pwqc_out_t                  m_data,
    input  wire logic                            cfg_we,
    input  wire logic [pwqc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [pwqc_pkg::MASK_W-1:0]     cfg_wdata
);
    import pwqc_pkg::*;

    localparam int ADDR_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

    pwqc_cfg_t   cfg;
    pwqc_entry_t rd_entry;
    pwqc_entry_t wb_entry;
    pwqc_rec_t   eval_rec;

    // pipeline registers
    logic                  s1_valid_reg;
    pwqc_in_t              s1_item_reg;
    logic                  s1_range_reg;
    logic                  s2_valid_reg;
    pwqc_rec_t             s2_reg;
    logic                  s3_valid_reg;
    pwqc_rec_t             s3_reg;
    logic [DIV_PROD_W-1:0] s3_prod_reg;
    logic                  m_valid_reg;
    pwqc_out_t             m_data_reg;

    logic                  in_accept;
    logic                  in_range;
    logic                  hazard;
    logic                  s1_ready;
    logic                  s2_ready;
    logic                  s3_ready;
    logic                  out_ready;
    logic                  mem_we;
    logic [DIV_PROD_W-1:0] prod;
    logic [PERIOD_W-1:0]   quotient;

    pwqc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // ready chain, back to front
    assign out_ready = !m_valid_reg || m_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    // interlock: a pin still in flight has a pending write-back
    assign hazard = (s1_valid_reg && (s1_item_reg.pin_index == s_data.pin_index)) ||
                    (s2_valid_reg && (s2_reg.pin == s_data.pin_index)) ||
                    (s3_valid_reg && (s3_reg.pin == s_data.pin_index));

    assign s_ready   = aresetn && s1_ready && !hazard;
    assign in_accept = s_valid && s_ready;
    assign in_range  = {1'b0, s_data.pin_index} < (PIN_W + 1)'(NUM_PINS);

    // write back when the result leaves the last stage
    assign mem_we = s3_valid_reg && out_ready && s3_reg.wr_en;

    pwqc_state_mem #(
        .NUM_PINS (NUM_PINS),
        .ADDR_W   (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept && in_range),
        .rd_addr (s_data.pin_index[ADDR_W-1:0]),
        .wr_en   (mem_we),
        .wr_addr (s3_reg.pin[ADDR_W-1:0]),
        .wr_data (wb_entry),
        .rd_data (rd_entry)
    );

    pwqc_eval u_eval (
        .item     (s1_item_reg),
        .in_range (s1_range_reg),
        .cfg      (cfg),
        .entry_in (rd_entry),
        .rec      (eval_rec)
    );

    // period: delta / 1000 by reciprocal multiply, shift in the next stage
    assign prod     = DIV_PROD_W'(s2_reg.delta) * DIV_PROD_W'(DIV1000_RECIP);
    assign quotient = s3_prod_reg[DIV1000_SHIFT +: PERIOD_W];

    always_comb begin
        wb_entry           = s3_reg.entry;
        wb_entry.period_ms = s3_reg.counted ? quotient : s3_reg.entry.period_ms;
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_accept;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_item_reg  <= s_data;
            s1_range_reg <= in_range;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_reg <= eval_rec;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_reg      <= s2_reg;
            s3_prod_reg <= prod;
        end
        if (out_ready && s3_valid_reg) begin
            m_data_reg.event_pin    <= s3_reg.pin;
            m_data_reg.status       <= s3_reg.status;
            m_data_reg.pulse_total  <= wb_entry.pulse_count;
            m_data_reg.period_ms    <= wb_entry.period_ms;
            m_data_reg.width_us     <= s3_reg.width;
            m_data_reg.reject_count <= wb_entry.reject;
            m_data_reg.period_valid <= (wb_entry.reject == '0);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // no two stages ever hold the same pin
    a_no_pin_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s3_valid_reg) |-> (s2_reg.pin != s3_reg.pin))
        else $error("two in-flight transactions share a pin");

    a_no_pin_overlap_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (s2_valid_reg || s3_valid_reg)) |->
        ((!s2_valid_reg || (s1_item_reg.pin_index != s2_reg.pin)) &&
         (!s3_valid_reg || (s1_item_reg.pin_index != s3_reg.pin))))
        else $error("stage 1 pin collides with a pending write-back");

    // an accepted transaction always lands in stage 1
    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> s1_valid_reg)
        else $error("accepted transaction lost before stage 1");

    // a counted pulse must be written back
    a_counted_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && (s3_reg.status == ST_COUNTED)) |-> s3_reg.wr_en)
        else $error("counted pulse without write-back");

    // only pins that exist are ever written
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ({1'b0, s3_reg.pin} < (PIN_W + 1)'(NUM_PINS)))
        else $error("write-back to a pin beyond the pin count");
`endif

endmodule

`default_nettype wire

// ===== rtl/pwqc_cfg.sv =====
// Configuration registers of the pulse width qualified counter.
// Also holds the expected window bounds derived from them.
// Depends on pwqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwqc_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [pwqc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [pwqc_pkg::MASK_W-1:0]     cfg_wdata,
    output pwqc_pkg::pwqc_cfg_t                  cfg
);
    import pwqc_pkg::*;

    logic [MASK_W-1:0]  enable_reg;
    logic [MASK_W-1:0]  invert_reg;
    logic [EXP_W-1:0]   expected_reg;
    logic [BOUND_W-1:0] min_reg;
    logic [BOUND_W-1:0] max_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [WIN_W-1:0]   exp_lo_reg;
    logic [WIN_W-1:0]   exp_hi_reg;
    logic [WIN_W-1:0]   centre;
    logic [WIN_W-1:0]   exp_lo_next;
    logic [WIN_W-1:0]   exp_hi_next;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= '0;
            invert_reg   <= '0;
            expected_reg <= '0;
            min_reg      <= DEF_MIN_WIDTH_US;
            max_reg      <= DEF_MAX_WIDTH_US;
            tol_reg      <= DEF_TOLERANCE_US;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ENABLE_MASK:   enable_reg   <= cfg_wdata;
                REG_INVERTED_MASK: invert_reg   <= cfg_wdata;
                REG_EXPECTED_MS:   expected_reg <= cfg_wdata[EXP_W-1:0];
                REG_MIN_WIDTH:     min_reg      <= cfg_wdata[BOUND_W-1:0];
                REG_MAX_WIDTH:     max_reg      <= cfg_wdata[BOUND_W-1:0];
                REG_TOLERANCE:     tol_reg      <= cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // expected window: centre +/- tolerance, low end floored at zero
    always_comb begin
        centre      = WIN_W'(expected_reg) * WIN_W'(US_PER_MS);
        exp_lo_next = (centre > WIN_W'(tol_reg)) ? centre - WIN_W'(tol_reg) : '0;
        exp_hi_next = centre + WIN_W'(tol_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_lo_reg <= '0;
            exp_hi_reg <= WIN_W'(DEF_TOLERANCE_US);
        end else begin
            exp_lo_reg <= exp_lo_next;
            exp_hi_reg <= exp_hi_next;
        end
    end

    assign cfg.enable_mask       = enable_reg;
    assign cfg.inverted_mask     = invert_reg;
    assign cfg.expected_width_ms = expected_reg;
    assign cfg.min_width_us      = min_reg;
    assign cfg.max_width_us      = max_reg;
    assign cfg.exp_lo            = exp_lo_reg;
    assign cfg.exp_hi            = exp_hi_reg;

endmodule

`default_nettype wire

// ===== rtl/pwqc_state_mem.sv =====
// Per-pin state memory: one synchronous RAM of entries, registered read.
// Valid bits make an unwritten entry read as its reset value.
// Depends on pwqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwqc_state_mem #(
    parameter int NUM_PINS = 64,
    parameter int ADDR_W   = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  pwqc_pkg::pwqc_entry_t  wr_data,
    output pwqc_pkg::pwqc_entry_t  rd_data
);
    import pwqc_pkg::*;

    pwqc_entry_t         mem [NUM_PINS];
    pwqc_entry_t         rdata_reg;
    logic                rd_vld_reg;
    logic [NUM_PINS-1:0] vld_reg;

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // per-entry valid bits, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rdata_reg : ENTRY_RESET;

endmodule

`default_nettype wire

// ===== rtl/pwqc_eval.sv =====
// Edge evaluation: level fix-up, pulse width, window check and the
// updated per-pin entry (period field settled later). Depends on pwqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwqc_eval (
    input  pwqc_pkg::pwqc_in_t    item,
    input  wire logic             in_range,
    input  pwqc_pkg::pwqc_cfg_t   cfg,
    input  pwqc_pkg::pwqc_entry_t entry_in,
    output pwqc_pkg::pwqc_rec_t   rec
);
    import pwqc_pkg::*;

    logic              enabled;
    logic              level;
    logic [TICK_W-1:0] width;
    logic              out_default;
    logic              out_expected;
    logic              outside;

    always_comb begin
        enabled      = cfg.enable_mask[item.pin_index];
        level        = item.edge_level ^ cfg.inverted_mask[item.pin_index];
        width        = item.tick_us - entry_in.last_rise;
        out_default  = (width < TICK_W'(cfg.min_width_us)) ||
                       (width > TICK_W'(cfg.max_width_us));
        out_expected = (width < TICK_W'(cfg.exp_lo)) || (width > TICK_W'(cfg.exp_hi));
        outside      = (cfg.expected_width_ms == '0) ? out_default : out_expected;

        rec.pin     = item.pin_index;
        rec.status  = ST_DISABLED;
        rec.width   = '0;
        rec.delta   = item.tick_us - entry_in.last_accept;
        rec.counted = 1'b0;
        rec.wr_en   = 1'b0;
        rec.entry   = entry_in;

        priority if (!in_range) begin
            // no storage behind this pin: all-zero totals
            rec.entry = '0;
        end else if (!enabled) begin
            rec.status = ST_DISABLED;
        end else if (level) begin
            rec.wr_en           = 1'b1;
            rec.status          = ST_RISE;
            rec.entry.last_rise = item.tick_us;
            rec.entry.seen_rise = 1'b1;
        end else if (!entry_in.seen_rise) begin
            rec.wr_en  = 1'b1;
            rec.status = ST_NO_RISE;
            if (entry_in.reject != REJECT_MAX) begin
                rec.entry.reject = entry_in.reject + 1'b1;
            end
        end else begin
            rec.wr_en           = 1'b1;
            rec.width           = width;
            rec.entry.seen_rise = 1'b0;
            if (outside) begin
                rec.status = (cfg.expected_width_ms == '0) ? ST_DEFAULT_WIN
                                                           : ST_EXPECTED_WIN;
                if (entry_in.reject != REJECT_MAX) begin
                    rec.entry.reject = entry_in.reject + 1'b1;
                end
            end else begin
                rec.status            = ST_COUNTED;
                rec.counted           = 1'b1;
                rec.entry.pulse_count = entry_in.pulse_count + 1'b1;
                rec.entry.last_accept = item.tick_us;
                if (entry_in.reject != '0) begin
                    rec.entry.reject = entry_in.reject - 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/pwqc_checker.sv =====
// Scoreboard for the pulse width qualified counter: watches the edge, result
// and register-write ports, predicts each result and compares it field by field.
// Depends on pwqc_pkg.
`timescale 1ns / 1ps

module pwqc_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  pwqc_pkg::pwqc_in_t                   s_data,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  pwqc_pkg::pwqc_out_t                  m_data,
    input  wire logic                            cfg_we,
    input  wire logic [pwqc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [pwqc_pkg::MASK_W-1:0]     cfg_wdata,
    output int                                   fail_count,
    output int                                   pending_results
);
    import pwqc_pkg::*;

    localparam int PINS = 64;

    // Shadow of the configuration registers
    logic [MASK_W-1:0]  en_mask;
    logic [MASK_W-1:0]  inv_mask;
    logic [EXP_W-1:0]   exp_ms;
    logic [BOUND_W-1:0] min_us;
    logic [BOUND_W-1:0] max_us;
    logic [TOL_W-1:0]   tol_us;

    // Per-pin counter state
    logic [COUNT_W-1:0]  pulse_count  [PINS];
    logic [TICK_W-1:0]   accept_tick  [PINS];
    logic [TICK_W-1:0]   rise_tick    [PINS];
    logic [PERIOD_W-1:0] period_last  [PINS];
    logic [REJECT_W-1:0] ignore_count [PINS];
    logic                armed        [PINS];

    // Results still owed by the block, oldest first
    pwqc_out_t expected_results [$];
    pwqc_out_t want;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val, input logic [PIN_W-1:0] pin);
        if (got !== exp_val)
            report_mismatch($sformatf("pin %0d %s got %0d expected %0d",
                                      pin, name, got, exp_val));
    endtask

    // Apply one edge to the shadow state and build the result it causes
    function automatic pwqc_out_t predict_edge(input pwqc_in_t ev);
        pwqc_out_t        res;
        logic [PIN_W-1:0] p;
        logic             lvl;
        logic [31:0]      width;
        logic [31:0]      centre;
        logic [31:0]      lo;
        logic [31:0]      hi;
        status_t          st;

        p     = ev.pin_index;
        lvl   = ev.edge_level ^ inv_mask[p];
        width = '0;
        if (!en_mask[p]) begin
            st = ST_DISABLED;
        end else if (lvl) begin
            rise_tick[p] = ev.tick_us;
            armed[p]     = 1'b1;
            st           = ST_RISE;
        end else if (!armed[p]) begin
            st = ST_NO_RISE;
        end else begin
            width    = ev.tick_us - rise_tick[p];
            armed[p] = 1'b0;
            if (exp_ms == 0) begin
                st = (width < min_us || width > max_us) ? ST_DEFAULT_WIN : ST_COUNTED;
            end else begin
                centre = exp_ms * 1000;
                lo     = (centre > tol_us) ? centre - tol_us : 32'd0;
                hi     = centre + tol_us;
                st     = (width < lo || width > hi) ? ST_EXPECTED_WIN : ST_COUNTED;
            end
            if (st == ST_COUNTED) begin
                pulse_count[p] = pulse_count[p] + 1;
                period_last[p] = (ev.tick_us - accept_tick[p]) / 1000;
                accept_tick[p] = ev.tick_us;
                if (ignore_count[p] != 0)
                    ignore_count[p] = ignore_count[p] - 1;
            end
        end

        // Every rejected falling edge raises the saturating ignore counter
        if ((st == ST_NO_RISE || st == ST_DEFAULT_WIN || st == ST_EXPECTED_WIN) &&
            ignore_count[p] != REJECT_MAX)
            ignore_count[p] = ignore_count[p] + 1;

        res.event_pin    = p;
        res.status       = st;
        res.pulse_total  = pulse_count[p];
        res.period_ms    = period_last[p];
        res.width_us     = width;
        res.reject_count = ignore_count[p];
        res.period_valid = (ignore_count[p] == 0);
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            en_mask  = '0;
            inv_mask = '0;
            exp_ms   = '0;
            min_us   = DEF_MIN_WIDTH_US;
            max_us   = DEF_MAX_WIDTH_US;
            tol_us   = DEF_TOLERANCE_US;
            for (int p = 0; p < PINS; p++) begin
                pulse_count[p]  = '0;
                accept_tick[p]  = '0;
                rise_tick[p]    = '0;
                period_last[p]  = '0;
                ignore_count[p] = REJECT_RESET;
                armed[p]        = 1'b0;
            end
            expected_results.delete();
            pending_results = 0;
        end else begin
            // Result side first: a result never belongs to an edge taken this cycle
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result transaction on pin %0d with none pending",
                                              m_data.event_pin));
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_pin", m_data.event_pin, want.event_pin, want.event_pin);
                    check_field("status", m_data.status, want.status, want.event_pin);
                    check_field("pulse_total", m_data.pulse_total, want.pulse_total,
                                want.event_pin);
                    check_field("period_ms", m_data.period_ms, want.period_ms, want.event_pin);
                    check_field("width_us", m_data.width_us, want.width_us, want.event_pin);
                    check_field("reject_count", m_data.reject_count, want.reject_count,
                                want.event_pin);
                    check_field("period_valid", m_data.period_valid, want.period_valid,
                                want.event_pin);
                end
            end

            if (s_valid && s_ready)
                expected_results.push_back(predict_edge(s_data));

            // Register writes
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ENABLE_MASK:   en_mask  = cfg_wdata;
                    REG_INVERTED_MASK: inv_mask = cfg_wdata;
                    REG_EXPECTED_MS:   exp_ms   = cfg_wdata[EXP_W-1:0];
                    REG_MIN_WIDTH:     min_us   = cfg_wdata[BOUND_W-1:0];
                    REG_MAX_WIDTH:     max_us   = cfg_wdata[BOUND_W-1:0];
                    REG_TOLERANCE:     tol_us   = cfg_wdata[TOL_W-1:0];
                    default: ;
                endcase
            end

            pending_results = expected_results.size();
        end
    end

endmodule

// ===== test/pulse_width_qualified_counter_test.sv =====
// Testbench top for the pulse width qualified counter: drives edge events and
// register settings with random idling and back-pressure, gives the verdict.
// Depends on pwqc_pkg, pulse_width_qualified_counter and pwqc_checker.
`timescale 1ns / 1ps

module pulse_width_qualified_counter_test;
    import pwqc_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int PHASE_EDGES  = 225;
    localparam int RANDOM_PHASES = 8;
    localparam int SAT_EDGES    = 40;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pwqc_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    pwqc_out_t             m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [MASK_W-1:0]     cfg_wdata = '0;

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    int stall_left  = 0;
    int sent_count  = 0;
    bit calm        = 1'b0;

    // Stimulus-side copy of the settings, used only to shape pulses
    logic [MASK_W-1:0]  cfg_en  = '0;
    logic [MASK_W-1:0]  cfg_inv = '0;
    logic [EXP_W-1:0]   cfg_exp = '0;
    logic [BOUND_W-1:0] cfg_min = DEF_MIN_WIDTH_US;
    logic [BOUND_W-1:0] cfg_max = DEF_MAX_WIDTH_US;
    logic [TOL_W-1:0]   cfg_tol = DEF_TOLERANCE_US;

    bit [TICK_W-1:0] now_tick [64];

    always #6 aclk = ~aclk;

    pulse_width_qualified_counter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    pwqc_checker scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Mostly short gaps, a few long ones
    function automatic int idle_length();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result-side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
                stall_left <= idle_length();
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One edge transaction; valid holds until accepted
    task automatic send_edge(input logic [PIN_W-1:0] pin, input logic level,
                             input logic [TICK_W-1:0] tick);
        pwqc_in_t item;
        int       gap;
        item.pin_index  = pin;
        item.edge_level = level;
        item.tick_us    = tick;
        gap = idle_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    // Edge given by its logical level, before the per-pin inversion
    task automatic send_logic(input logic [PIN_W-1:0] pin, input logic level,
                              input logic [TICK_W-1:0] tick);
        send_edge(pin, level ^ cfg_inv[pin], tick);
    endtask

    // Let everything in flight come out before touching registers
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic put_reg(input reg_index_t idx, input logic [MASK_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [MASK_W-1:0] en, input logic [MASK_W-1:0] inv,
                              input logic [EXP_W-1:0] exp_ms,
                              input logic [BOUND_W-1:0] mn, input logic [BOUND_W-1:0] mx,
                              input logic [TOL_W-1:0] tol);
        put_reg(REG_ENABLE_MASK, en);
        put_reg(REG_INVERTED_MASK, inv);
        put_reg(REG_EXPECTED_MS, exp_ms);
        put_reg(REG_MIN_WIDTH, mn);
        put_reg(REG_MAX_WIDTH, mx);
        put_reg(REG_TOLERANCE, tol);
        cfg_we <= 1'b0;
        @(posedge aclk);
        cfg_en  = en;
        cfg_inv = inv;
        cfg_exp = exp_ms;
        cfg_min = mn;
        cfg_max = mx;
        cfg_tol = tol;
    endtask

    task automatic random_config();
        logic [MASK_W-1:0]  en;
        logic [MASK_W-1:0]  inv;
        logic [EXP_W-1:0]   exp_ms;
        logic [BOUND_W-1:0] mn;
        logic [BOUND_W-1:0] mx;
        logic [TOL_W-1:0]   tol;
        case ($urandom_range(0, 3))
            0:       en = '1;
            1:       en = {$urandom, $urandom} | {$urandom, $urandom};
            2:       en = {$urandom, $urandom};
            default: en = ~(64'd1 << $urandom_range(0, 63));
        endcase
        case ($urandom_range(0, 2))
            0:       inv = '0;
            1:       inv = '1;
            default: inv = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 5))
            0, 1, 2: exp_ms = 0;
            3:       exp_ms = 1;
            4:       exp_ms = 120;
            default: exp_ms = $urandom_range(1, 120);
        endcase
        case ($urandom_range(0, 5))
            0: begin mn = DEF_MIN_WIDTH_US; mx = DEF_MAX_WIDTH_US; end
            1: begin mn = $urandom_range(0, 60000); mx = mn + $urandom_range(0, 200000); end
            2: begin mn = 0; mx = 1000000; end
            3: begin mn = 0; mx = 0; end
            4: begin mn = 1000000; mx = 1000000; end
            default: begin
                // lower bound above upper bound: nothing passes
                mx = $urandom_range(0, 500000);
                mn = mx + $urandom_range(1, 500000);
            end
        endcase
        case ($urandom_range(0, 3))
            0:       tol = 0;
            1:       tol = 100000;
            2:       tol = $urandom_range(0, 5000);
            default: tol = $urandom_range(0, 100000);
        endcase
        set_config(en, inv, exp_ms, mn, mx, tol);
    endtask

    // Width near the edges of the active window, sometimes anywhere
    function automatic logic [TICK_W-1:0] pick_width();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] centre;
        int          r;
        if (cfg_exp == 0) begin
            lo = cfg_min;
            hi = cfg_max;
        end else begin
            centre = cfg_exp * 1000;
            lo     = (centre > cfg_tol) ? centre - cfg_tol : 32'd0;
            hi     = centre + cfg_tol;
        end
        r = $urandom_range(0, 99);
        if (lo > hi || r < 8)
            return $urandom_range(0, 1100000);
        if (r < 50)
            return lo + $urandom_range(0, hi - lo);
        if (r < 62)
            return lo;
        if (r < 74)
            return hi;
        if (r < 84)
            return lo - 1;
        if (r < 94)
            return hi + 1;
        return $urandom;
    endfunction

    function automatic logic [TICK_W-1:0] next_tick(input logic [PIN_W-1:0] pin);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            now_tick[pin] += $urandom_range(0, 2000000);
        else if (r < 95)
            now_tick[pin] += $urandom_range(0, 50000);
        else
            now_tick[pin] += $urandom;
        return now_tick[pin];
    endfunction

    // Mostly complete pulses on a few busy pins, plus broken sequences and noise
    task automatic random_phase(input int target);
        int               base;
        int               r;
        logic [PIN_W-1:0] pin;
        logic [TICK_W-1:0] rise;
        base = sent_count;
        while (sent_count - base < target) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 1))
                pin = 6'($urandom_range(0, 63));
            else if ($urandom_range(0, 1))
                pin = 6'($urandom_range(0, 3));
            else
                pin = 6'($urandom_range(60, 63));
            if (r < 70) begin
                rise = next_tick(pin);
                send_logic(pin, 1'b1, rise);
                now_tick[pin] = rise + pick_width();
                send_logic(pin, 1'b0, now_tick[pin]);
            end else if (r < 85) begin
                send_logic(pin, 1'b0, next_tick(pin));
            end else if (r < 92) begin
                send_logic(pin, 1'b1, next_tick(pin));
            end else begin
                send_edge(pin, 1'($urandom_range(0, 1)), $urandom);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: every pin disabled
        send_logic(6'd5, 1'b1, 32'd1000);
        send_logic(6'd63, 1'b0, 32'd2000);
        drain();

        // Default window, bounds inclusive
        set_config('1, '0, 0, DEF_MIN_WIDTH_US, DEF_MAX_WIDTH_US, DEF_TOLERANCE_US);
        send_logic(6'd0, 1'b0, 32'd0);          // fall with no rise before it
        send_logic(6'd0, 1'b1, 32'd0);
        send_logic(6'd0, 1'b0, 32'd30000);      // exactly min
        send_logic(6'd0, 1'b1, 32'd100000);
        send_logic(6'd0, 1'b0, 32'd220000);     // exactly max
        send_logic(6'd0, 1'b1, 32'd300000);
        send_logic(6'd0, 1'b0, 32'd329999);     // one short
        send_logic(6'd0, 1'b1, 32'd400000);
        send_logic(6'd0, 1'b0, 32'd520001);     // one long
        send_logic(6'd63, 1'b1, 32'hFFFF_FFF0);
        send_logic(6'd63, 1'b0, 32'h0000_EA60); // width across the tick wrap
        send_logic(6'd63, 1'b1, 32'hFFFF_FFFF);
        send_logic(6'd63, 1'b1, 32'hFFFF_FFFF); // second rise restarts the pulse
        send_logic(6'd63, 1'b0, 32'h0001_0000);
        drain();

        // Inverted pins, expected window floored at zero
        set_config('1, '1, 1, DEF_MIN_WIDTH_US, DEF_MAX_WIDTH_US, DEF_TOLERANCE_US);
        send_logic(6'd1, 1'b1, 32'd5000);
        send_logic(6'd1, 1'b0, 32'd5000);       // zero width
        send_logic(6'd1, 1'b1, 32'd10000);
        send_logic(6'd1, 1'b0, 32'd13001);      // just above expected + tolerance
        drain();

        // Widest expected window
        set_config('1, '0, 120, 0, 0, 100000);
        send_logic(6'd2, 1'b1, 32'd0);
        send_logic(6'd2, 1'b0, 32'd220000);
        send_logic(6'd2, 1'b1, 32'd300000);
        send_logic(6'd2, 1'b0, 32'd319999);
        drain();

        // Lower bound above upper bound
        set_config('1, '0, 0, 1000000, 0, 0);
        send_logic(6'd3, 1'b1, 32'd0);
        send_logic(6'd3, 1'b0, 32'd500000);
        drain();

        // Random settings and traffic
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_config();
            calm = (ph % 3 == 2);
            random_phase(PHASE_EDGES);
            calm = 1'b0;
            drain();
        end

        // A long run of rejects on one pin raises its ignore counter, then one
        // counted pulse lowers it again
        set_config('1, '0, 0, DEF_MIN_WIDTH_US, DEF_MAX_WIDTH_US, DEF_TOLERANCE_US);
        calm = 1'b1;
        for (int i = 0; i < SAT_EDGES; i++)
            send_logic(6'd62, 1'b0, 32'(i));
        send_logic(6'd62, 1'b1, 32'd100000000);
        send_logic(6'd62, 1'b0, 32'd100050000);
        calm = 1'b0;
        drain();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
